[hw/rtl/nrmc_pkg.sv]
// Shared constants, types and helper functions for the RMC sentence parser.
// Used by nrmc_scan, nrmc_format and the top level; depends on nothing.
`default_nettype none

package nrmc_pkg;

	localparam int LINE_MAX    = 80;
	localparam int FIELD_MAX   = 20;
	localparam int FRAC_DIGITS = 4;

	localparam int LPOS_W  = $clog2(LINE_MAX);
	localparam int FPOS_W  = $clog2(FIELD_MAX);
	localparam int FNUM_W  = 4;
	localparam int FRAC_W  = $clog2(FRAC_DIGITS + 1);
	localparam int MAG_W   = 30;
	localparam int SCALE_W = $clog2(10 ** FRAC_DIGITS + 1);
	localparam int PROD_W  = MAG_W + SCALE_W;
	localparam int WIN_W   = 24;
	localparam int TDATA_W = 112;

	localparam logic [MAG_W-1:0]  MAG_LIMIT  = MAG_W'(999999999);
	localparam logic [FNUM_W-1:0] FNUM_LAST  = {FNUM_W{1'b1}};
	localparam logic [FPOS_W-1:0] HEADER_LEN = FPOS_W'(6);
	localparam logic [11:0]       YEAR_BASE  = 12'd2000;

	// Field numbers within a sentence.
	localparam logic [FNUM_W-1:0] FLD_HEADER = 4'd0;
	localparam logic [FNUM_W-1:0] FLD_TIME   = 4'd1;
	localparam logic [FNUM_W-1:0] FLD_LAT    = 4'd3;
	localparam logic [FNUM_W-1:0] FLD_NS     = 4'd4;
	localparam logic [FNUM_W-1:0] FLD_LON    = 4'd5;
	localparam logic [FNUM_W-1:0] FLD_EW     = 4'd6;
	localparam logic [FNUM_W-1:0] FLD_DATE   = 4'd9;

	// Characters with a meaning to the parser.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_W     = 8'h57;

	// Snapshot of one finished line, handed from the scanner to the formatter.
	typedef struct packed {
		logic [WIN_W-1:0]  time_win;
		logic [WIN_W-1:0]  date_win;
		logic [MAG_W-1:0]  lat_mag;
		logic [FRAC_W-1:0] lat_frac;
		logic              lat_south;
		logic [MAG_W-1:0]  lon_mag;
		logic [FRAC_W-1:0] lon_frac;
		logic              lon_west;
	} snap_t;

	typedef struct packed {
		logic [6:0]         hour;
		logic [6:0]         minute;
		logic [6:0]         second;
		logic signed [30:0] latitude;
		logic signed [30:0] longitude;
		logic [6:0]         day;
		logic [6:0]         month;
		logic [11:0]        year;
	} rmc_t;

	function automatic logic [7:0] header_char(input logic [2:0] idx);
		logic [7:0] ch;
		case (idx)
			3'd0:    ch = 8'h24; // '$'
			3'd1:    ch = 8'h47; // 'G'
			3'd2:    ch = 8'h50; // 'P'
			3'd3:    ch = 8'h52; // 'R'
			3'd4:    ch = 8'h4D; // 'M'
			3'd5:    ch = 8'h43; // 'C'
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// Appends one decimal digit to a magnitude, saturating at the limit.
	function automatic logic [MAG_W-1:0] digit_push(input logic [MAG_W-1:0] mag,
			input logic [3:0] d);
		logic [MAG_W+3:0] v;
		v = ({4'b0, mag} << 3) + ({4'b0, mag} << 1) + (MAG_W+4)'(d);
		return (v > (MAG_W+4)'(MAG_LIMIT)) ? MAG_LIMIT : v[MAG_W-1:0];
	endfunction

	// Power of ten that pads a coordinate to the full number of fraction digits.
	function automatic logic [SCALE_W-1:0] pad_scale(input logic [FRAC_W-1:0] cnt);
		logic [SCALE_W-1:0] r;
		r = SCALE_W'(1);
		for (int i = 0; i < FRAC_DIGITS; i++) begin
			if (FRAC_W'(i) >= cnt) begin
				r = SCALE_W'(r * SCALE_W'(10));
			end
		end
		return r;
	endfunction

	// Two BCD digits to binary.
	function automatic logic [6:0] bcd_pair(input logic [7:0] b);
		return 7'(7'(b[7:4]) * 7'd10 + 7'(b[3:0]));
	endfunction

endpackage

`default_nettype wire

[hw/rtl/nrmc_scan.sv]
// Character scanner: splits lines into fields and collects time, position and date.
// Holds the snapshot register of a finished RMC line; depends on nrmc_pkg.
`default_nettype none

module nrmc_scan (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          byte_accept,
	input  wire logic [7:0]    rx_byte,
	input  wire logic          drain,
	output logic               snap_valid_s1,
	output nrmc_pkg::snap_t    snap_s1
);
	import nrmc_pkg::*;

	typedef struct packed {
		logic [LPOS_W-1:0] lpos;
		logic [FNUM_W-1:0] fnum;
		logic [FPOS_W-1:0] fpos;
		logic              hdr_ok;
		logic              stopped;
		logic              seen_dot;
		logic [WIN_W-1:0]  time_win;
		logic [WIN_W-1:0]  date_win;
		logic [MAG_W-1:0]  lat_mag;
		logic [FRAC_W-1:0] lat_frac;
		logic              lat_south;
		logic [MAG_W-1:0]  lon_mag;
		logic [FRAC_W-1:0] lon_frac;
		logic              lon_west;
	} scan_t;

	localparam scan_t SCAN_RESET = '{
		lpos: '0, fnum: '0, fpos: '0, hdr_ok: 1'b1, stopped: 1'b0, seen_dot: 1'b0,
		time_win: '0, date_win: '0, lat_mag: '0, lat_frac: '0, lat_south: 1'b0,
		lon_mag: '0, lon_frac: '0, lon_west: 1'b0
	};

	scan_t      st_q;
	scan_t      st_d;
	logic       is_digit;
	logic [3:0] digit;
	logic       hdr_final;
	logic       line_end;

	assign is_digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);
	assign digit    = rx_byte[3:0];
	assign line_end = byte_accept && (rx_byte == CH_LF);
	// The header field must also have been exactly six characters long.
	assign hdr_final = st_q.hdr_ok && !((st_q.fnum == FLD_HEADER) && (st_q.fpos != HEADER_LEN));

	always_comb begin
		st_d = st_q;
		if (rx_byte == CH_LF) begin
			st_d = SCAN_RESET;
		end else if (st_q.lpos < LPOS_W'(LINE_MAX - 1)) begin
			if (rx_byte == CH_NUL) begin
				// A NUL drops the rest of the line up to the newline.
				st_d.lpos = LPOS_W'(LINE_MAX - 1);
			end else begin
				st_d.lpos = st_q.lpos + LPOS_W'(1);
				if (rx_byte == CH_COMMA) begin
					if ((st_q.fnum == FLD_HEADER) && (st_q.fpos != HEADER_LEN)) begin
						st_d.hdr_ok = 1'b0;
					end
					if (st_q.fnum != FNUM_LAST) begin
						st_d.fnum = st_q.fnum + FNUM_W'(1);
					end
					st_d.fpos     = '0;
					st_d.stopped  = 1'b0;
					st_d.seen_dot = 1'b0;
				end else if (st_q.fpos < FPOS_W'(FIELD_MAX - 1)) begin
					st_d.fpos = st_q.fpos + FPOS_W'(1);
					case (st_q.fnum)
						FLD_HEADER: begin
							if ((st_q.fpos < HEADER_LEN) &&
									(rx_byte != header_char(st_q.fpos[2:0]))) begin
								st_d.hdr_ok = 1'b0;
							end
						end
						FLD_TIME: begin
							if (!st_q.stopped) begin
								if (is_digit) begin
									st_d.time_win = {st_q.time_win[WIN_W-5:0], digit};
								end else begin
									st_d.stopped = 1'b1;
								end
							end
						end
						FLD_DATE: begin
							if (!st_q.stopped) begin
								if (is_digit) begin
									st_d.date_win = {st_q.date_win[WIN_W-5:0], digit};
								end else begin
									st_d.stopped = 1'b1;
								end
							end
						end
						FLD_LAT: begin
							if (!st_q.stopped) begin
								if (is_digit) begin
									if (!st_q.seen_dot) begin
										st_d.lat_mag = digit_push(st_q.lat_mag, digit);
									end else if (st_q.lat_frac < FRAC_W'(FRAC_DIGITS)) begin
										st_d.lat_frac = st_q.lat_frac + FRAC_W'(1);
										st_d.lat_mag  = digit_push(st_q.lat_mag, digit);
									end
								end else if ((rx_byte == CH_DOT) && !st_q.seen_dot) begin
									st_d.seen_dot = 1'b1;
								end else begin
									st_d.stopped = 1'b1;
								end
							end
						end
						FLD_LON: begin
							if (!st_q.stopped) begin
								if (is_digit) begin
									if (!st_q.seen_dot) begin
										st_d.lon_mag = digit_push(st_q.lon_mag, digit);
									end else if (st_q.lon_frac < FRAC_W'(FRAC_DIGITS)) begin
										st_d.lon_frac = st_q.lon_frac + FRAC_W'(1);
										st_d.lon_mag  = digit_push(st_q.lon_mag, digit);
									end
								end else if ((rx_byte == CH_DOT) && !st_q.seen_dot) begin
									st_d.seen_dot = 1'b1;
								end else begin
									st_d.stopped = 1'b1;
								end
							end
						end
						FLD_NS: begin
							if ((st_q.fpos == '0) && (rx_byte == CH_S)) begin
								st_d.lat_south = 1'b1;
							end
						end
						FLD_EW: begin
							if ((st_q.fpos == '0) && (rx_byte == CH_W)) begin
								st_d.lon_west = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= SCAN_RESET;
		end else if (byte_accept) begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (line_end && hdr_final) begin
			snap_valid_s1 <= 1'b1;
		end else if (drain) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (line_end && hdr_final) begin
			snap_s1.time_win  <= st_q.time_win;
			snap_s1.date_win  <= st_q.date_win;
			snap_s1.lat_mag   <= st_q.lat_mag;
			snap_s1.lat_frac  <= st_q.lat_frac;
			snap_s1.lat_south <= st_q.lat_south;
			snap_s1.lon_mag   <= st_q.lon_mag;
			snap_s1.lon_frac  <= st_q.lon_frac;
			snap_s1.lon_west  <= st_q.lon_west;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/nrmc_format.sv]
// Result formatter: pads and signs the coordinates and converts BCD time and date.
// Purely combinational; depends on nrmc_pkg.
`default_nettype none

module nrmc_format (
	input  wire nrmc_pkg::snap_t snap,
	output nrmc_pkg::rmc_t       fix
);
	import nrmc_pkg::*;

	logic [PROD_W-1:0] lat_prod;
	logic [PROD_W-1:0] lon_prod;
	logic [MAG_W-1:0]  lat_sat;
	logic [MAG_W-1:0]  lon_sat;

	// Missing fraction digits count as zeros: scale by the matching power of ten.
	assign lat_prod = PROD_W'(snap.lat_mag) * PROD_W'(pad_scale(snap.lat_frac));
	assign lon_prod = PROD_W'(snap.lon_mag) * PROD_W'(pad_scale(snap.lon_frac));
	assign lat_sat  = (lat_prod > PROD_W'(MAG_LIMIT)) ? MAG_LIMIT : lat_prod[MAG_W-1:0];
	assign lon_sat  = (lon_prod > PROD_W'(MAG_LIMIT)) ? MAG_LIMIT : lon_prod[MAG_W-1:0];

	assign fix.hour      = bcd_pair(snap.time_win[23:16]);
	assign fix.minute    = bcd_pair(snap.time_win[15:8]);
	assign fix.second    = bcd_pair(snap.time_win[7:0]);
	assign fix.latitude  = snap.lat_south ? (31'sd0 - signed'(31'(lat_sat))) :
		signed'(31'(lat_sat));
	assign fix.longitude = snap.lon_west ? (31'sd0 - signed'(31'(lon_sat))) :
		signed'(31'(lon_sat));
	assign fix.day       = bcd_pair(snap.date_win[23:16]);
	assign fix.month     = bcd_pair(snap.date_win[15:8]);
	assign fix.year      = YEAR_BASE + 12'(bcd_pair(snap.date_win[7:0]));

endmodule

`default_nettype wire

[hw/rtl/nmea_rmc_sentence_parser_top.sv]
// NMEA 0183 RMC sentence parser, top level with the result output buffer.
// Instantiates nrmc_scan and nrmc_format; depends on nrmc_pkg.
//
// Usage: received ASCII characters enter on the s_ stream, one per transaction,
// in s_tdata[7:0]. Each line ends with a newline. When the first field of the
// line is exactly $GPRMC, one fix transaction leaves on the m_ stream; other
// lines give nothing. The fix carries time, signed latitude and longitude in
// (d)ddmm.mmmm form scaled by 10000 (ten-thousandths of a minute), and the date.
// Throughput: one character per clock cycle while s_tready is high. The
// character scanner updates its state in the cycle a character is taken.
// A fix reaches m_tvalid through the snapshot register, then the output register
// (by way of the skid register when the output register is still occupied).
// A two-entry output buffer (output register plus skid register) lets the
// scanner keep taking characters while a fix waits; s_tready drops only when
// both buffer entries and the snapshot register are occupied.
// Reset (arst_n low) clears the line state and empties all buffers.
`default_nettype none

module nmea_rmc_sentence_parser_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [7:0]    s_tdata,   // [7:0] rx_byte
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// m_tdata from bit 0: hour[6:0], minute[13:7], second[20:14], latitude[51:21],
	// longitude[82:52], day[89:83], month[96:90], year[108:97], zeros[111:109]
	output logic [nrmc_pkg::TDATA_W-1:0] m_tdata
);
	import nrmc_pkg::*;

	logic  byte_accept;
	logic  drain;
	logic  snap_valid_s1;
	snap_t snap_s1;
	rmc_t  fix;
	rmc_t  out_q;
	rmc_t  skid_q;
	logic  out_valid_q;
	logic  skid_valid_q;
	logic  pop;

	assign s_tready    = !snap_valid_s1 || !skid_valid_q;
	assign byte_accept = s_tvalid && s_tready;
	assign drain       = snap_valid_s1 && !skid_valid_q;
	assign pop         = out_valid_q && m_tready;

	nrmc_scan u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_accept   (byte_accept),
		.rx_byte       (s_tdata),
		.drain         (drain),
		.snap_valid_s1 (snap_valid_s1),
		.snap_s1       (snap_s1)
	);

	nrmc_format u_format (
		.snap (snap_s1),
		.fix  (fix)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= drain;
			end else begin
				out_valid_q  <= drain;
			end
		end else if (drain) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
				if (drain) begin
					skid_q <= fix;
				end
			end else if (drain) begin
				out_q <= fix;
			end
		end else if (drain) begin
			skid_q <= fix;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.year, out_q.month, out_q.day, out_q.longitude,
		out_q.latitude, out_q.second, out_q.minute, out_q.hour};

endmodule

`default_nettype wire
